// ===== rtl/qctc_pkg.sv =====
// ----------------------------------------------------------------------------
// qctc_pkg
// Types and constants shared by the four-channel counter/timer.
// ----------------------------------------------------------------------------
package qctc_pkg;

  localparam int unsigned CHANNELS = 4;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_TICK  = 3'd2,
    OP_TRIG  = 3'd3,
    OP_ACK   = 3'd4,
    OP_RETI  = 3'd5
  } op_e;

  // control word bits
  localparam int unsigned CW_CTRL  = 0;
  localparam int unsigned CW_SRST  = 1;
  localparam int unsigned CW_TCF   = 2;
  localparam int unsigned CW_TRIG  = 3;
  localparam int unsigned CW_P256  = 5;
  localparam int unsigned CW_CNTR  = 6;
  localparam int unsigned CW_IE    = 7;

  localparam logic [8:0] COUNT_FULL = 9'd256;
  localparam logic [7:0] NO_VECTOR  = 8'hff;

  typedef struct packed {
    logic       en;
    op_e        op;
    logic       sel;
    logic [7:0] data;
    logic       autostart;
    logic       ack;
    logic       reti;
  } chan_ctrl_t;

  typedef struct packed {
    logic [7:0] count_low;
    logic       cpend;
    logic       pend_q;
    logic       serv_q;
    logic       pend_d;
    logic       serv_d;
    logic       hit;
  } chan_stat_t;

endpackage

// ===== rtl/qctc_channel.sv =====
// ----------------------------------------------------------------------------
// qctc_channel
// One counter/timer channel: control word, time constant, prescaler and
// down counter with reload, plus its interrupt request and service flags.
// ----------------------------------------------------------------------------
module qctc_channel
  import qctc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chan_ctrl_t ctrl_i,
  output chan_stat_t stat_o
);

  logic [8:0] count_q, count_d;
  logic [8:0] tc_q, tc_d;
  logic [7:0] accum_q, accum_d;
  logic [7:0] cw_q, cw_d;
  logic       p256_q, p256_d;
  logic       frozen_q, frozen_d;
  logic       was_frozen_q, was_frozen_d;
  logic       started_q, started_d;
  logic       cpend_q, cpend_d;
  logic       first_q, first_d;
  logic       pend_q, pend_d;
  logic       serv_q, serv_d;

  logic [8:0]  acc_inc;
  logic [4:0]  amount;
  logic        do_count;
  logic [9:0]  diff;
  logic [9:0]  under;
  logic        zero_hit;
  logic [12:0] rem;
  logic [8:0]  reload;
  logic        hit;

  // remainder of the undershoot (below 16) by the time constant
  always_comb begin
    rem = {9'b0, under[3:0]};
    for (int i = 3; i >= 0; i--) begin
      if (rem >= ({4'b0, tc_q} << i)) begin
        rem = rem - ({4'b0, tc_q} << i);
      end
    end
    reload = tc_q - {5'b0, rem[3:0]};
  end

  assign acc_inc  = {1'b0, accum_q} + 9'd1;
  assign diff     = {1'b0, count_q} - {5'b0, amount};
  assign under    = {5'b0, amount} - {1'b0, count_q};
  assign zero_hit = diff[9] || (diff == 10'd0);

  always_comb begin
    count_d      = count_q;
    tc_d         = tc_q;
    accum_d      = accum_q;
    cw_d         = cw_q;
    p256_d       = p256_q;
    frozen_d     = frozen_q;
    was_frozen_d = was_frozen_q;
    started_d    = started_q;
    cpend_d      = cpend_q;
    first_d      = first_q;
    pend_d       = pend_q;
    serv_d       = serv_q;
    amount       = 5'd1;
    do_count     = 1'b0;
    hit          = 1'b0;

    case (ctrl_i.op)
      OP_WRITE: begin
        if (ctrl_i.sel) begin
          if (cpend_q) begin
            tc_d    = (ctrl_i.data == 8'd0) ? COUNT_FULL : {1'b0, ctrl_i.data};
            cpend_d = 1'b0;
            if (was_frozen_q || first_q) begin
              count_d  = tc_d;
              accum_d  = 8'd0;
              frozen_d = 1'b0;
              first_d  = 1'b0;
            end
          end else if (ctrl_i.data[CW_CTRL]) begin
            p256_d    = ctrl_i.data[CW_P256];
            cpend_d   = ctrl_i.data[CW_TCF];
            frozen_d  = ctrl_i.data[CW_SRST];
            started_d = ctrl_i.autostart || !ctrl_i.data[CW_TRIG];
            cw_d      = ctrl_i.data;
            if (ctrl_i.data[CW_SRST]) begin
              was_frozen_d = 1'b1;
            end
            if (ctrl_i.data[CW_SRST] || !ctrl_i.data[CW_IE]) begin
              pend_d = 1'b0;
            end
          end
        end
      end
      OP_TICK: begin
        if (!cw_q[CW_CNTR] && started_q && !frozen_q) begin
          was_frozen_d = 1'b0;
          if (p256_q) begin
            amount  = {4'b0, acc_inc[8]};
            accum_d = acc_inc[7:0];
          end else begin
            amount  = acc_inc[8:4];
            accum_d = {4'b0, acc_inc[3:0]};
          end
          do_count = (amount != 5'd0);
        end
      end
      OP_TRIG: begin
        if (ctrl_i.sel) begin
          if (!cw_q[CW_CNTR]) begin
            started_d = 1'b1;
          end else if (!frozen_q) begin
            was_frozen_d = 1'b0;
            do_count     = 1'b1;
          end
        end
      end
      OP_ACK: begin
        if (ctrl_i.ack) begin
          pend_d = 1'b0;
          serv_d = 1'b1;
        end
      end
      OP_RETI: begin
        if (ctrl_i.reti) begin
          pend_d = 1'b0;
          serv_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_count) begin
      if (zero_hit) begin
        count_d = reload;
        hit     = 1'b1;
        if (cw_q[CW_IE]) begin
          pend_d = 1'b1;
        end
      end else begin
        count_d = diff[8:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= COUNT_FULL;
      tc_q         <= COUNT_FULL;
      accum_q      <= 8'd0;
      cw_q         <= 8'd0;
      p256_q       <= 1'b1;
      frozen_q     <= 1'b0;
      was_frozen_q <= 1'b0;
      started_q    <= 1'b0;
      cpend_q      <= 1'b0;
      first_q      <= 1'b1;
      pend_q       <= 1'b0;
      serv_q       <= 1'b0;
    end else if (ctrl_i.en) begin
      count_q      <= count_d;
      tc_q         <= tc_d;
      accum_q      <= accum_d;
      cw_q         <= cw_d;
      p256_q       <= p256_d;
      frozen_q     <= frozen_d;
      was_frozen_q <= was_frozen_d;
      started_q    <= started_d;
      cpend_q      <= cpend_d;
      first_q      <= first_d;
      pend_q       <= pend_d;
      serv_q       <= serv_d;
    end
  end

  assign stat_o.count_low = count_q[7:0];
  assign stat_o.cpend     = cpend_q;
  assign stat_o.pend_q    = pend_q;
  assign stat_o.serv_q    = serv_q;
  assign stat_o.pend_d    = pend_d;
  assign stat_o.serv_d    = serv_d;
  assign stat_o.hit       = hit;

endmodule

// ===== rtl/qctc_irq.sv =====
// ----------------------------------------------------------------------------
// qctc_irq
// Fixed-priority interrupt logic: acknowledge grant, return-from-interrupt
// release and the request and daisy-chain outputs after the transfer.
// ----------------------------------------------------------------------------
module qctc_irq
  import qctc_pkg::*;
(
  input  logic [CHANNELS-1:0] pend_q_i,
  input  logic [CHANNELS-1:0] serv_q_i,
  input  logic [CHANNELS-1:0] pend_d_i,
  input  logic [CHANNELS-1:0] serv_d_i,
  input  logic                daisy_in_i,
  output logic [CHANNELS-1:0] ack_o,
  output logic                ack_hit_o,
  output logic [1:0]          ack_chan_o,
  output logic [CHANNELS-1:0] reti_o,
  output logic                int_request_o,
  output logic                daisy_out_o
);

  logic blocked;
  logic found;
  logic req_done;
  logic req;

  always_comb begin
    ack_o      = '0;
    ack_hit_o  = 1'b0;
    ack_chan_o = 2'd0;
    blocked    = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!blocked) begin
        if (serv_q_i[c]) begin
          blocked = 1'b1;
        end else if (pend_q_i[c]) begin
          blocked    = 1'b1;
          ack_o[c]   = 1'b1;
          ack_hit_o  = 1'b1;
          ack_chan_o = 2'(c);
        end
      end
    end
  end

  always_comb begin
    reti_o = '0;
    found  = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!found && serv_q_i[c]) begin
        found     = 1'b1;
        reti_o[c] = 1'b1;
      end
    end
  end

  always_comb begin
    req      = 1'b0;
    req_done = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!req_done) begin
        if (serv_d_i[c]) begin
          req_done = 1'b1;
        end else if (pend_d_i[c]) begin
          req_done = 1'b1;
          req      = 1'b1;
        end
      end
    end
  end

  assign int_request_o = daisy_in_i && req;
  assign daisy_out_o   = daisy_in_i && !(|serv_d_i);

endmodule

// ===== rtl/quad_counter_timer_daisy_chain.sv =====
// ----------------------------------------------------------------------------
// quad_counter_timer_daisy_chain
// Four-channel counter/timer with daisy-chained vectored interrupts.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid/tready          tuser: operation, channel
//                                        tdata: write_data, daisy_in
//   m_axis   out  tvalid/tready          tdata: read_data, int_request,
//                                        daisy_out, zero_pulse_mask
//   cfg      in   cfg_we_i               cfg_wdata_i: trigger_autostart
//
// One transfer per cycle while m_axis is not stalled. An item sits in the input
// register, is processed combinationally against the channel state and lands
// in the result register. The input register refills while the result is taken,
// so a stall on m_axis holds one item in each register. Reset is
// asynchronous and leaves every channel idle at a count of 256.
// ----------------------------------------------------------------------------
module quad_counter_timer_daisy_chain
  import qctc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] daisy_in
  input  logic [4:0]  s_axis_tuser,  // [2:0] operation, [4:3] channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] read_data, [8] int_request,
                                     // [9] daisy_out, [13:10] zero_pulse_mask
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic        in_valid_q;
  logic [2:0]  in_op_q;
  logic [1:0]  in_chan_q;
  logic [7:0]  in_data_q;
  logic        in_daisy_q;
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        autostart_q;
  logic [4:0]  vbase_q;

  logic        advance;
  op_e         op;
  chan_ctrl_t  ctrl [CHANNELS];
  chan_stat_t  stat [CHANNELS];

  logic [CHANNELS-1:0] pend_q, serv_q, pend_d, serv_d, ack, reti;
  logic                ack_hit;
  logic [1:0]          ack_chan;
  logic                int_request;
  logic                daisy_out;
  logic [7:0]          read_data;
  logic [3:0]          zero_mask;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign op            = op_e'(in_op_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= s_axis_tuser[2:0];
      in_chan_q  <= s_axis_tuser[4:3];
      in_data_q  <= s_axis_tdata[7:0];
      in_daisy_q <= s_axis_tdata[8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autostart_q <= 1'b0;
    end else if (cfg_we_i) begin
      autostart_q <= cfg_wdata_i;
    end
  end

  generate
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      assign ctrl[c].en        = advance;
      assign ctrl[c].op        = op;
      assign ctrl[c].sel       = (in_chan_q == 2'(c));
      assign ctrl[c].data      = in_data_q;
      assign ctrl[c].autostart = autostart_q;
      assign ctrl[c].ack       = ack[c];
      assign ctrl[c].reti      = reti[c];

      qctc_channel u_chan (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[c]),
        .stat_o (stat[c])
      );

      assign pend_q[c] = stat[c].pend_q;
      assign serv_q[c] = stat[c].serv_q;
      assign pend_d[c] = stat[c].pend_d;
      assign serv_d[c] = stat[c].serv_d;
    end
  endgenerate

  qctc_irq u_irq (
    .pend_q_i      (pend_q),
    .serv_q_i      (serv_q),
    .pend_d_i      (pend_d),
    .serv_d_i      (serv_d),
    .daisy_in_i    (in_daisy_q),
    .ack_o         (ack),
    .ack_hit_o     (ack_hit),
    .ack_chan_o    (ack_chan),
    .reti_o        (reti),
    .int_request_o (int_request),
    .daisy_out_o   (daisy_out)
  );

  // channel 0 takes a plain byte as vector base unless a constant is due
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbase_q <= 5'd0;
    end else if (advance && (op == OP_WRITE) && (in_chan_q == 2'd0) &&
                 !in_data_q[CW_CTRL] && !stat[0].cpend) begin
      vbase_q <= in_data_q[7:3];
    end
  end

  always_comb begin
    read_data = 8'd0;
    case (op)
      OP_READ: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (in_chan_q == 2'(c)) begin
            read_data = stat[c].count_low;
          end
        end
      end
      OP_ACK: begin
        read_data = ack_hit ? {vbase_q, ack_chan, 1'b0} : NO_VECTOR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    zero_mask = 4'd0;
    for (int c = 0; c < CHANNELS; c++) begin
      zero_mask[c] = stat[c].hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, zero_mask, daisy_out, int_request, read_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== dv/tb_quad_counter_timer_daisy_chain.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quad_counter_timer_daisy_chain
// Self-checking bench for the four-channel counter/timer.
//
// A queue of bus operations feeds the s_axis driver. Each accepted transfer
// runs through a behavioural model of the channels, prescalers, reloads and
// interrupt daisy chain, and the predicted response is queued. The monitor
// compares every m_axis transfer with the oldest prediction. Both sides idle
// in random bursts. The run steps through both autostart settings, opening
// with a short directed sequence and then mostly random channel set-ups,
// tick and trigger bursts, acknowledges and returns.
// ----------------------------------------------------------------------------
module tb_quad_counter_timer_daisy_chain;
  import qctc_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int PHASES = 4;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] ch;
    logic [7:0] wdata;
    logic       din;
  } bus_op_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       dout;
    logic [3:0] zmask;
  } ctc_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [4:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_wdata_i;

  quad_counter_timer_daisy_chain dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // channel model
  logic [8:0] down_cnt   [CHANNELS];
  logic [8:0] time_const [CHANNELS];
  logic [7:0] pre_acc    [CHANNELS];
  logic [7:0] ctrl_word  [CHANNELS];
  logic       pre_256    [CHANNELS];
  logic       frozen     [CHANNELS];
  logic       was_frozen [CHANNELS];
  logic       running    [CHANNELS];
  logic       const_due  [CHANNELS];
  logic       first_load [CHANNELS];
  logic       irq_pend   [CHANNELS];
  logic       irq_serv   [CHANNELS];
  logic [4:0] vec_base;
  logic       autostart_cfg;

  bus_op_t   bus_ops[$];
  ctc_resp_t pending_responses[$];

  bit src_hold;
  int src_gap, snk_gap;
  int src_idle_pct, snk_idle_pct;
  int mismatches;
  int op_seen[8];
  int zero_pulses, vectors_given;

  function automatic logic count_down(int cn, int amount);
    int   v;
    logic hit;
    v = int'(down_cnt[cn]) - amount;
    hit = 1'b0;
    while (v <= 0) begin
      v += int'(time_const[cn]);
      if (ctrl_word[cn][CW_IE]) irq_pend[cn] = 1'b1;
      hit = 1'b1;
    end
    down_cnt[cn] = v[8:0];
    return hit;
  endfunction

  function automatic ctc_resp_t counter_timer_response(bus_op_t t);
    ctc_resp_t r;
    int        c;
    int        cn;
    int        acc;
    int        amount;
    r = '0;
    cn = int'(t.ch);
    case (t.op)
      OP_WRITE: begin
        if (const_due[cn]) begin
          time_const[cn] = (t.wdata == 8'd0) ? COUNT_FULL : {1'b0, t.wdata};
          const_due[cn] = 1'b0;
          if (was_frozen[cn] || first_load[cn]) begin
            down_cnt[cn] = time_const[cn];
            pre_acc[cn] = 8'd0;
            frozen[cn] = 1'b0;
            first_load[cn] = 1'b0;
          end
        end else if (t.wdata[CW_CTRL]) begin
          pre_256[cn] = t.wdata[CW_P256];
          const_due[cn] = t.wdata[CW_TCF];
          frozen[cn] = t.wdata[CW_SRST];
          if (t.wdata[CW_SRST]) was_frozen[cn] = 1'b1;
          running[cn] = autostart_cfg || !t.wdata[CW_TRIG];
          ctrl_word[cn] = t.wdata;
          if (t.wdata[CW_SRST] || !t.wdata[CW_IE]) irq_pend[cn] = 1'b0;
        end else if (cn == 0) begin
          vec_base = t.wdata[7:3];
        end
      end
      OP_READ: r.rdata = down_cnt[cn][7:0];
      OP_TICK: begin
        for (c = 0; c < CHANNELS; c++) begin
          if (ctrl_word[c][CW_CNTR] || !running[c] || frozen[c]) continue;
          was_frozen[c] = 1'b0;
          acc = int'(pre_acc[c]) + 1;
          amount = pre_256[c] ? (acc >> 8) : (acc >> 4);
          pre_acc[c] = pre_256[c] ? acc[7:0] : {4'd0, acc[3:0]};
          if (amount != 0 && count_down(c, amount)) r.zmask[c] = 1'b1;
        end
      end
      OP_TRIG: begin
        if (!ctrl_word[cn][CW_CNTR]) begin
          running[cn] = 1'b1;
        end else if (!frozen[cn]) begin
          was_frozen[cn] = 1'b0;
          if (count_down(cn, 1)) r.zmask[cn] = 1'b1;
        end
      end
      OP_ACK: begin
        r.rdata = NO_VECTOR;
        for (c = 0; c < CHANNELS; c++) begin
          if (irq_serv[c]) break;
          if (irq_pend[c]) begin
            irq_pend[c] = 1'b0;
            irq_serv[c] = 1'b1;
            r.rdata = {vec_base, c[1:0], 1'b0};
            break;
          end
        end
      end
      OP_RETI: begin
        for (c = 0; c < CHANNELS; c++) begin
          if (irq_serv[c]) begin
            irq_serv[c] = 1'b0;
            irq_pend[c] = 1'b0;
            break;
          end
        end
      end
      default: ;
    endcase
    r.dout = t.din;
    for (c = 0; c < CHANNELS; c++)
      if (irq_serv[c]) r.dout = 1'b0;
    if (t.din) begin
      for (c = 0; c < CHANNELS; c++) begin
        if (irq_serv[c]) break;
        if (irq_pend[c]) begin
          r.irq = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_op(logic [2:0] op, logic [1:0] ch, logic [7:0] wdata,
                                   logic din);
    bus_op_t t;
    t.op = op;
    t.ch = ch;
    t.wdata = wdata;
    t.din = din;
    bus_ops.push_back(t);
  endfunction

  function automatic logic rand_din();
    return $urandom_range(0, 9) != 0;
  endfunction

  task automatic add_random_ops(int n);
    int         target;
    int         kind;
    int         k;
    logic [1:0] ch;
    logic [7:0] cw;
    target = bus_ops.size() + n;
    while (bus_ops.size() < target) begin
      kind = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      if (kind < 15) begin
        cw = 8'($urandom_range(0, 255));
        cw[CW_CTRL] = 1'b1;
        if ($urandom_range(0, 9) < 8) cw[CW_TCF] = 1'b1;
        if ($urandom_range(0, 3) != 0) cw[CW_SRST] = 1'b0;
        queue_op(OP_WRITE, ch, cw, rand_din());
        if (cw[CW_TCF]) begin
          if ($urandom_range(0, 9) < 7)
            queue_op(OP_WRITE, ch, 8'($urandom_range(0, 5)), rand_din());
          else
            queue_op(OP_WRITE, ch, 8'($urandom_range(0, 255)), rand_din());
        end
      end else if (kind < 40) begin
        repeat ($urandom_range(1, 20)) queue_op(OP_TICK, 2'($urandom_range(0, 3)),
                                                8'($urandom_range(0, 255)), rand_din());
      end else if (kind < 52) begin
        repeat ($urandom_range(1, 6)) queue_op(OP_TRIG, ch, 8'($urandom_range(0, 255)),
                                               rand_din());
      end else if (kind < 62) begin
        queue_op(OP_ACK, ch, 8'($urandom_range(0, 255)), rand_din());
      end else if (kind < 70) begin
        queue_op(OP_RETI, ch, 8'($urandom_range(0, 255)), rand_din());
      end else if (kind < 80) begin
        queue_op(OP_READ, ch, 8'($urandom_range(0, 255)), rand_din());
      end else if (kind < 85) begin
        queue_op(OP_WRITE, 2'd0, 8'($urandom_range(0, 255)) & 8'hfe, rand_din());
      end else if (kind < 90) begin
        queue_op(OP_WRITE, 2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)) & 8'hfe,
                 rand_din());
      end else if (kind < 93) begin
        k = $urandom_range(0, 1);
        queue_op(k ? OP_SPARE7 : OP_SPARE6, ch, 8'($urandom_range(0, 255)), rand_din());
      end else begin
        queue_op(3'($urandom_range(0, 7)), ch, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((bus_ops.size() != 0 || pending_responses.size() != 0) && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic set_autostart(logic v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    autostart_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // source side
  always @(negedge clk_i) begin
    if (!src_hold) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (bus_ops.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {bus_ops[0].ch, bus_ops[0].op};
        s_axis_tdata <= {7'd0, bus_ops[0].din, bus_ops[0].wdata};
        src_hold = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk_i) begin
    if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < snk_idle_pct) snk_gap = $urandom_range(1, 19);
    end
  end

  // response check first, then take the new transfer into the model
  always @(posedge clk_i) begin
    ctc_resp_t got;
    ctc_resp_t want;
    bus_op_t   t;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata = m_axis_tdata[7:0];
        got.irq = m_axis_tdata[8];
        got.dout = m_axis_tdata[9];
        got.zmask = m_axis_tdata[13:10];
        if (pending_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected response rdata=%02h irq=%b dout=%b zero=%b",
                     $realtime, got.rdata, got.irq, got.dout, got.zmask);
        end else begin
          want = pending_responses.pop_front();
          if (got.rdata !== want.rdata || got.irq !== want.irq ||
              got.dout !== want.dout || got.zmask !== want.zmask) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp rdata=%02h irq=%b dout=%b zero=%b / got %02h %b %b %b",
                       $realtime, want.rdata, want.irq, want.dout, want.zmask,
                       got.rdata, got.irq, got.dout, got.zmask);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        t = bus_ops.pop_front();
        src_hold = 1'b0;
        if ($urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 19);
        want = counter_timer_response(t);
        pending_responses.push_back(want);
        op_seen[t.op]++;
        zero_pulses += $countones(want.zmask);
        if (t.op == OP_ACK && want.rdata != NO_VECTOR) vectors_given++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int ph;
    int c;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    for (c = 0; c < CHANNELS; c++) begin
      down_cnt[c] = COUNT_FULL;
      time_const[c] = COUNT_FULL;
      pre_acc[c] = 8'd0;
      ctrl_word[c] = 8'd0;
      pre_256[c] = 1'b1;
      frozen[c] = 1'b0;
      was_frozen[c] = 1'b0;
      running[c] = 1'b0;
      const_due[c] = 1'b0;
      first_load[c] = 1'b1;
      irq_pend[c] = 1'b0;
      irq_serv[c] = 1'b0;
    end
    vec_base = 5'd0;
    autostart_cfg = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      src_gap = 0;
      snk_gap = 0;
      case (ph)
        0: begin src_idle_pct = 15; snk_idle_pct = 15; end
        1: begin src_idle_pct = 30; snk_idle_pct = 25; end
        2: begin src_idle_pct = 8;  snk_idle_pct = 0;  end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      set_autostart(ph[0]);
      if (ph == 0) begin
        queue_op(OP_READ,   2'd0, 8'h00, 1'b1); // full count reads as zero
        queue_op(OP_ACK,    2'd0, 8'h00, 1'b1); // nothing requesting
        queue_op(OP_RETI,   2'd1, 8'h00, 1'b1); // nothing in service
        queue_op(OP_SPARE6, 2'd3, 8'hff, 1'b0);
        queue_op(OP_SPARE7, 2'd2, 8'h5a, 1'b1);
        queue_op(OP_WRITE,  2'd0, 8'h48, 1'b1); // vector base
        queue_op(OP_WRITE,  2'd1, 8'hfe, 1'b1); // data byte off channel 0, ignored
        queue_op(OP_WRITE,  2'd2, 8'hc5, 1'b1); // counter, IE, constant follows
        queue_op(OP_WRITE,  2'd2, 8'h01, 1'b1);
        queue_op(OP_TRIG,   2'd2, 8'h00, 1'b1);
        queue_op(OP_READ,   2'd2, 8'h00, 1'b1);
        queue_op(OP_WRITE,  2'd3, 8'h87, 1'b1); // timer with soft reset
        queue_op(OP_WRITE,  2'd3, 8'h00, 1'b1); // zero constant means 256
        queue_op(OP_TICK,   2'd0, 8'h00, 1'b0);
        queue_op(OP_ACK,    2'd1, 8'hff, 1'b0);
        queue_op(OP_TRIG,   2'd2, 8'h00, 1'b1); // request while in service
        queue_op(OP_RETI,   2'd0, 8'h00, 1'b1);
        queue_op(OP_WRITE,  2'd1, 8'had, 1'b1); // timer waiting for trigger
        queue_op(OP_WRITE,  2'd1, 8'hff, 1'b1);
        queue_op(OP_TRIG,   2'd1, 8'h00, 1'b1);
        queue_op(OP_WRITE,  2'd0, 8'h05, 1'b1);
        queue_op(OP_WRITE,  2'd0, 8'h01, 1'b1);
        queue_op(OP_TICK,   2'd0, 8'h00, 1'b1);
        queue_op(OP_TICK,   2'd0, 8'h00, 1'b1);
        queue_op(OP_READ,   2'd3, 8'h00, 1'b1);
      end
      add_random_ops(420);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      mismatches += pending_responses.size();
      $display("%0d responses never arrived", pending_responses.size());
    end
    $display("covered %0d writes, %0d reads, %0d ticks, %0d triggers, %0d spare ops",
             op_seen[OP_WRITE], op_seen[OP_READ], op_seen[OP_TICK], op_seen[OP_TRIG],
             op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
    $display("%0d acks (%0d vectors), %0d returns, %0d zero pulses, %0d autostart phases",
             op_seen[OP_ACK], vectors_given, op_seen[OP_RETI], zero_pulses, PHASES);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
